/* hw/rtl/aes_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

    localparam int ROUNDS_DEF = 10;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HI = 1'b0,
        REG_KEY_LO = 1'b1
    } cfg_reg_t;

    typedef logic [7:0]   byte_t;
    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic byte_t xtime(input byte_t x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of the block sits at bits 127-8n; row n%4, column n/4
    function automatic byte_t get_b(input block_t s, input int n);
        get_b = s[127 - 8*n -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int n = 0; n < 16; n++)
        begin
            t[127 - 8*n -: 8] = SBOX[get_b(s, (n + ((n % 4) * 4)) % 16)];
        end
        sub_shift = t;
    endfunction

    function automatic block_t mix(input block_t s);
        block_t t;
        byte_t a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_b(s, 4*c);
            a1 = get_b(s, 4*c + 1);
            a2 = get_b(s, 4*c + 2);
            a3 = get_b(s, 4*c + 3);
            t[127 - 32*c -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[127 - 32*c - 8 -: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[127 - 32*c - 16 -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[127 - 32*c - 24 -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix = t;
    endfunction

    // one step of the key schedule: round key r-1 to round key r
    function automatic block_t key_step(input block_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_step = {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/aes_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] hi;
    logic [63:0] lo;

    modport source (output valid, output hi, output lo, input ready);
    modport sink   (input valid, input hi, input lo, output ready);
endinterface

`default_nettype wire

/* hw/rtl/aes128_encrypt_core.sv */
`timescale 1ns / 1ps
// Path: a request is registered in st_reg[0] with the key added, then passes st_reg[1] to st_reg[ROUNDS].
// Throughput: one request per cycle while not stalled; one unrolled stage per round,
// each stage also expands its own round key from the previous stage's key.
// A stall freezes the whole pipeline; a request enters whenever the last stage is empty or being taken.
// Reset: rst_n async active low clears valid bits and the key registers to zero.
`default_nettype none

module aes128_encrypt_core
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    aes_stream_if.sink                req,
    aes_stream_if.source              rsp
);

    logic [63:0] key_hi_reg, key_lo_reg;
    logic        vld_reg  [ROUNDS+1];
    block_t      st_reg   [ROUNDS+1];
    block_t      rk_reg   [ROUNDS];
    byte_t       rc_reg   [ROUNDS];
    logic        adv;

    // stages move together; the last one holds while its result is not taken
    assign adv       = !vld_reg[ROUNDS] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vld_reg[ROUNDS];
    assign rsp.hi    = st_reg[ROUNDS][127:64];
    assign rsp.lo    = st_reg[ROUNDS][63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_HI: key_hi_reg <= cfg_data;
                REG_KEY_LO: key_lo_reg <= cfg_data;
                default:    key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ROUNDS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int i = 1; i <= ROUNDS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= {req.hi, req.lo} ^ {key_hi_reg, key_lo_reg};
            rk_reg[0] <= {key_hi_reg, key_lo_reg};
            rc_reg[0] <= 8'h01;
            for (int i = 1; i <= ROUNDS; i++)
            begin
                if (i < ROUNDS)
                begin
                    st_reg[i] <= mix(sub_shift(st_reg[i-1]))
                                 ^ key_step(rk_reg[i-1], rc_reg[i-1]);
                    rk_reg[i] <= key_step(rk_reg[i-1], rc_reg[i-1]);
                    rc_reg[i] <= xtime(rc_reg[i-1]);
                end
                else
                begin
                    st_reg[i] <= sub_shift(st_reg[i-1])
                                 ^ key_step(rk_reg[i-1], rc_reg[i-1]);
                end
            end
        end
    end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_KEY_HI;
    logic [63:0] cfg_data = '0;

    aes_stream_if req ();
    aes_stream_if rsp ();

    aes128_encrypt_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req.sink),
        .rsp(rsp.source)
    );

    always #4 clk = ~clk;

    localparam logic [7:0] SUB_TAB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    logic [63:0] key_hi_q = '0;
    logic [63:0] key_lo_q = '0;
    logic [7:0]  sched [176];

    block_pair_t pending_q[$];
    block_pair_t cipher_q[$];
    int errors = 0;
    bit req_gaps = 1'b1;
    bit rsp_gaps = 1'b1;
    int req_wait = 0;
    int rsp_wait = 0;

    function automatic logic [7:0] dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
    endfunction

    function automatic void build_schedule();
        logic [7:0] t [4];
        logic [7:0] rc;
        logic [7:0] first;
        rc = 8'h01;
        for (int n = 0; n < 8; n++)
        begin
            sched[n] = key_hi_q[63 - 8*n -: 8];
            sched[n + 8] = key_lo_q[63 - 8*n -: 8];
        end
        for (int n = 16; n < 176; n += 4)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = sched[n - 4 + j];
            if (n % 16 == 0)
            begin
                first = t[0];
                t[0] = SUB_TAB[t[1]] ^ rc;
                t[1] = SUB_TAB[t[2]];
                t[2] = SUB_TAB[t[3]];
                t[3] = SUB_TAB[first];
                rc = dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                sched[n + j] = sched[n - 16 + j] ^ t[j];
        end
    endfunction

    function automatic block_pair_t encrypt_block(input block_pair_t p);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        block_pair_t c;
        for (int n = 0; n < 8; n++)
        begin
            s[n] = p.hi[63 - 8*n -: 8] ^ sched[n];
            s[n + 8] = p.lo[63 - 8*n -: 8] ^ sched[n + 8];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int n = 0; n < 16; n++)
                t[n] = SUB_TAB[s[(n + (n % 4) * 4) % 16]];
            s = t;
            if (r < 10)
            begin
                for (int col = 0; col < 4; col++)
                begin
                    a0 = s[4*col]; a1 = s[4*col+1]; a2 = s[4*col+2]; a3 = s[4*col+3];
                    s[4*col]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[4*col+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[4*col+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[4*col+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            for (int n = 0; n < 16; n++)
                s[n] ^= sched[16*r + n];
        end
        for (int n = 0; n < 8; n++)
        begin
            c.hi[63 - 8*n -: 8] = s[n];
            c.lo[63 - 8*n -: 8] = s[n + 8];
        end
        return c;
    endfunction

    task automatic write_key(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_HI)
            key_hi_q = val;
        else
            key_lo_q = val;
        build_schedule();
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || cipher_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void push_block(input logic [63:0] hi, input logic [63:0] lo);
        block_pair_t p;
        p.hi = hi;
        p.lo = lo;
        pending_q.push_back(p);
    endfunction

    // driver: predict at accept time so key state matches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.hi <= '0;
            req.lo <= '0;
            req_wait <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                cipher_q.push_back(encrypt_block({req.hi, req.lo}));
                void'(pending_q.pop_front());
                req_wait <= req_gaps ? gap_len() : 0;
            end
            if (req.valid && !req.ready)
            begin
            end
            else if ((req.valid && req.ready ? req_gaps ? 1 : 0 : req_wait) != 0)
            begin
                req.valid <= 1'b0;
                if (!(req.valid && req.ready))
                    req_wait <= req_wait - 1;
            end
            else if (pending_q.size() != 0)
            begin
                req.valid <= 1'b1;
                req.hi <= pending_q[0].hi;
                req.lo <= pending_q[0].lo;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_wait <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (cipher_q.size() == 0)
                begin
                    $error("unexpected result hi=%h lo=%h", rsp.hi, rsp.lo);
                    errors++;
                end
                else
                begin
                    if (rsp.hi !== cipher_q[0].hi)
                    begin
                        $error("cipher_hi expected %h actual %h", cipher_q[0].hi, rsp.hi);
                        errors++;
                    end
                    if (rsp.lo !== cipher_q[0].lo)
                    begin
                        $error("cipher_lo expected %h actual %h", cipher_q[0].lo, rsp.lo);
                        errors++;
                    end
                    void'(cipher_q.pop_front());
                end
            end
            if (rsp_wait != 0)
            begin
                rsp.ready <= 1'b0;
                rsp_wait <= rsp_wait - 1;
            end
            else if (rsp_gaps && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                rsp_wait <= gap_len();
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        build_schedule();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset key (all zero)
        push_block('0, '0);
        push_block('1, '1);
        drain();

        // FIPS-197 appendix C.1 vector
        write_key(REG_KEY_HI, 64'h0001020304050607);
        write_key(REG_KEY_LO, 64'h08090a0b0c0d0e0f);
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block('0, '1);
        push_block('1, '0);
        for (int b = 0; b < 64; b += 9)
            push_block(64'd1 << b, ~(64'd1 << b));
        drain();

        // only one half changed: other half kept
        write_key(REG_KEY_HI, '1);
        push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        write_key(REG_KEY_LO, '1);
        push_block('0, '0);
        push_block('1, '1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            req_gaps = (ph % 3) != 2;
            rsp_gaps = (ph % 4) != 3;
            if (ph == 5)
                write_key(REG_KEY_HI, '0);
            else
                write_key(REG_KEY_HI, rand64());
            write_key(REG_KEY_LO, ph == 6 ? 64'h0 : rand64());
            for (int n = 0; n < 210; n++)
            begin
                push_block(rand64(), rand64());
                if (n == 100)
                begin
                    while (pending_q.size() != 0 || cipher_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
